@@ hw/rtl/alle_pkg.sv @@
// alle_pkg: shared constants, beat types and link reset values for the
// array linked list engine. No dependencies.
`timescale 1ns / 1ps

package alle_pkg;

    // store geometry: slot 0 is the sentinel, slots 1..CAPACITY hold entries
    localparam int CAPACITY = 63;
    localparam int DEPTH    = CAPACITY + 1;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 6;
    localparam int STEP_W   = IDX_W + 1;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // input beat
    typedef struct packed {
        logic [1:0]              cmd;
        logic [5:0]              position;
        logic signed [VAL_W-1:0] value;
    } in_t;

    // result beat
    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        count;
    } out_t;

    // request to the next-link memory
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } link_req_t;

    // next link after reset: sentinel and last slot end their chains,
    // every other slot points to the one above it
    function automatic logic [IDX_W-1:0] link_reset_val(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0 || idx == IDX_W'(CAPACITY)) begin
            res = '0;
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/alle_link_mem.sv @@
// alle_link_mem: next-link memory with one write and one registered read
// port; per-entry valid bits give the reset chain. Depends on alle_pkg.
`timescale 1ns / 1ps

module alle_link_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  alle_pkg::link_req_t         req,
    output logic [alle_pkg::IDX_W-1:0]  rd_data
);

    logic [alle_pkg::IDX_W-1:0] link_ram [alle_pkg::DEPTH];
    logic [alle_pkg::DEPTH-1:0] link_vld_reg;
    logic [alle_pkg::IDX_W-1:0] ram_q_reg;
    logic [alle_pkg::IDX_W-1:0] dflt_q_reg;
    logic                       hit_q_reg;

    // valid bits: an entry reads its reset link until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (req.wr_en) begin
            link_vld_reg[req.wr_addr] <= 1'b1;
        end
    end

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            link_ram[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            ram_q_reg  <= link_ram[req.rd_addr];
            dflt_q_reg <= alle_pkg::link_reset_val(req.rd_addr);
            hit_q_reg  <= link_vld_reg[req.rd_addr];
        end
    end

    assign rd_data = hit_q_reg ? ram_q_reg : dflt_q_reg;

endmodule

@@ hw/rtl/alle_seq.sv @@
// alle_seq: command sequencer; walks next links one read per cycle, then
// patches links, free stack, count and the value memory. Depends on alle_pkg.
`timescale 1ns / 1ps

module alle_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  alle_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output alle_pkg::out_t              out_data,
    output alle_pkg::link_req_t         link_req,
    input  logic [alle_pkg::IDX_W-1:0]  link_rd_data
);

    localparam int SW = 4;
    localparam logic [SW-1:0] S_IDLE    = 4'd0;
    localparam logic [SW-1:0] S_CHECK   = 4'd1;
    localparam logic [SW-1:0] S_CHAIN   = 4'd2;
    localparam logic [SW-1:0] S_FH_RD   = 4'd3;
    localparam logic [SW-1:0] S_FH_WT   = 4'd4;
    localparam logic [SW-1:0] S_INS_WR2 = 4'd5;
    localparam logic [SW-1:0] S_DEL_WR1 = 4'd6;
    localparam logic [SW-1:0] S_DEL_WR2 = 4'd7;
    localparam logic [SW-1:0] S_VAL_RD  = 4'd8;
    localparam logic [SW-1:0] S_VAL_WT  = 4'd9;
    localparam logic [SW-1:0] S_DONE    = 4'd10;

    localparam int IW = alle_pkg::IDX_W;
    localparam int TW = alle_pkg::STEP_W;
    localparam int VW = alle_pkg::VAL_W;
    localparam int CW = alle_pkg::CNT_W;

    logic [SW-1:0]         state_reg, state_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [5:0]            pos_reg, pos_next;
    logic signed [VW-1:0]  val_reg, val_next;
    logic [TW-1:0]         iss_reg, iss_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         s0_reg, s0_next;
    logic [IW-1:0]         s1_reg, s1_next;
    logic [IW-1:0]         s2_reg, s2_next;
    logic [IW-1:0]         fh_new_reg, fh_new_next;
    logic [IW-1:0]         free_head_reg, free_head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            status_reg, status_next;
    logic signed [VW-1:0]  rv_reg, rv_next;

    logic signed [VW-1:0]  val_ram [alle_pkg::DEPTH];
    logic signed [VW-1:0]  val_q_reg;
    logic                  val_wr_en;
    logic                  val_rd_en;

    logic [TW-1:0]         pos_ext;
    logic [TW-1:0]         cnt_ext;

    assign pos_ext = TW'(pos_reg);
    assign cnt_ext = TW'(count_reg);

    // handshake and result beat
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data = '{status: status_reg, read_value: rv_reg, count: count_reg};

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        iss_next       = iss_reg;
        pend_next      = pend_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        fh_new_next    = fh_new_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        rv_next        = rv_reg;
        link_req       = '0;
        val_wr_en      = 1'b0;
        val_rd_en      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next   = in_data.cmd;
                    pos_next   = in_data.position;
                    val_next   = in_data.value;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // validate and size the link walk
                rv_next     = '0;
                status_next = alle_pkg::ST_OK;
                s0_next     = '0;
                s1_next     = '0;
                s2_next     = '0;
                pend_next   = 1'b0;
                state_next  = S_DONE;
                case (cmd_reg) inside
                    alle_pkg::CMD_INSERT: begin
                        if (pos_reg == '0 || pos_ext > cnt_ext + TW'(1)) begin
                            status_next = alle_pkg::ST_BAD_POS;
                        end else if (free_head_reg == '0) begin
                            status_next = alle_pkg::ST_FULL;
                        end else begin
                            iss_next   = pos_ext;
                            state_next = S_CHAIN;
                        end
                    end
                    alle_pkg::CMD_DELETE, alle_pkg::CMD_READ: begin
                        if (count_reg == '0) begin
                            status_next = alle_pkg::ST_EMPTY;
                        end else if (pos_reg == '0 || pos_ext > cnt_ext) begin
                            status_next = alle_pkg::ST_BAD_POS;
                        end else begin
                            iss_next   = (cmd_reg == alle_pkg::CMD_DELETE) ?
                                         pos_ext + TW'(1) : pos_ext;
                            state_next = S_CHAIN;
                        end
                    end
                    default: begin
                        status_next = alle_pkg::ST_BAD_POS;
                    end
                endcase
            end
            S_CHAIN: begin
                // one link read per cycle, last three nodes kept
                if (pend_reg) begin
                    s0_next = s1_reg;
                    s1_next = s2_reg;
                    s2_next = link_rd_data;
                end
                if (iss_reg != '0) begin
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = pend_reg ? link_rd_data : '0;
                    iss_next         = iss_reg - TW'(1);
                    pend_next        = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (cmd_reg == alle_pkg::CMD_INSERT) begin
                            state_next = S_FH_RD;
                        end else if (cmd_reg == alle_pkg::CMD_DELETE) begin
                            state_next = S_DEL_WR1;
                        end else begin
                            state_next = S_VAL_RD;
                        end
                    end
                end
            end
            S_FH_RD: begin
                // fetch the link below the free head
                link_req.rd_en   = 1'b1;
                link_req.rd_addr = free_head_reg;
                state_next       = S_FH_WT;
            end
            S_FH_WT: begin
                // before -> new slot
                fh_new_next      = link_rd_data;
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = s1_reg;
                link_req.wr_data = free_head_reg;
                state_next       = S_INS_WR2;
            end
            S_INS_WR2: begin
                // new slot -> after, store value, pop free stack
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = free_head_reg;
                link_req.wr_data = s2_reg;
                val_wr_en        = 1'b1;
                free_head_next   = fh_new_reg;
                count_next       = count_reg + CW'(1);
                state_next       = S_DONE;
            end
            S_DEL_WR1: begin
                // before -> after
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = s0_reg;
                link_req.wr_data = s2_reg;
                state_next       = S_DEL_WR2;
            end
            S_DEL_WR2: begin
                // push victim onto free stack
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = s1_reg;
                link_req.wr_data = free_head_reg;
                free_head_next   = s1_reg;
                count_next       = count_reg - CW'(1);
                state_next       = S_DONE;
            end
            S_VAL_RD: begin
                val_rd_en  = 1'b1;
                state_next = S_VAL_WT;
            end
            S_VAL_WT: begin
                rv_next    = val_q_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            free_head_reg <= IW'(1);
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        iss_reg    <= iss_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        fh_new_reg <= fh_new_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
    end

    // value memory
    always_ff @(posedge aclk) begin
        if (val_wr_en) begin
            val_ram[free_head_reg] <= val_reg;
        end
        if (val_rd_en) begin
            val_q_reg <= val_ram[s2_reg];
        end
    end

`ifndef ASSERT_OFF
    // free stack empty exactly when the store is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg == '0) == (count_reg == CW'(alle_pkg::CAPACITY)))
        else $error("free head and count disagree");

    // an accepted beat goes straight to validation
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == S_CHECK))
        else $error("accepted beat not checked");

    // a completed insert adds exactly one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_WR2) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert count mismatch");

    // a completed delete pushes the victim slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEL_WR2) |=> (free_head_reg == $past(s1_reg)))
        else $error("delete did not free victim");
`endif

endmodule

@@ hw/rtl/array_linked_list_engine.sv @@
// array_linked_list_engine: top level; output register plus sequencer and
// next-link memory. Depends on alle_pkg, alle_link_mem, alle_seq.
//
//   channel   ports                      beat
//   input     s_valid s_ready s_data     cmd, position, value
//   result    m_valid m_ready m_data     status, read_value, count
//
// A rejected command goes from validation straight to the result; an accepted one
// walks next links from the sentinel at one link-memory read per cycle, then
// patches links or reads the value, and the next beat can be taken in the
// cycle after the result is registered.
// Synchronous active-low reset restores the empty list and free chain at once.
// A result waits in the output register while the next beat is taken; a
// further result holds the sequencer until that register empties.
`timescale 1ns / 1ps

module array_linked_list_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  alle_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output alle_pkg::out_t  m_data
);

    alle_pkg::link_req_t         link_req;
    logic [alle_pkg::IDX_W-1:0]  link_rd_data;
    logic                        res_valid;
    logic                        res_ready;
    alle_pkg::out_t              res_data;
    logic                        m_valid_reg, m_valid_next;
    alle_pkg::out_t              m_data_reg, m_data_next;

    alle_link_mem u_link_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (link_req),
        .rd_data (link_rd_data)
    );

    alle_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_data      (s_data),
        .out_valid    (res_valid),
        .out_ready    (res_ready),
        .out_data     (res_data),
        .link_req     (link_req),
        .link_rd_data (link_rd_data)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
